// File: rtl/nbs_pkg.sv
package nbs_pkg;

  // Default sizing of the block
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_KERNEL = 15;

  // Field and register widths
  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int KSIZE_W    = 4;
  localparam int KERN_W     = 5;              // holds any kernel side up to 31
  localparam int HIST_DEPTH = 2 ** KERN_W;    // column-sum history along a row

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd2;

  // Reset values of the registers
  localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd256;
  localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd256;
  localparam logic [KSIZE_W-1:0]    RST_KERNEL = 4'd3;

  // Reciprocals of K*K for odd K = 2*i+1, scaled by 2^24 and rounded up.
  // floor(p * RECIP[i] / 2^24) equals floor(p / (K*K)) for every 8-bit p.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam longint RECIP_ONE = 64'd1 << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP [16] = '{
    RECIP_W'((RECIP_ONE +   1 - 1) /   1),
    RECIP_W'((RECIP_ONE +   9 - 1) /   9),
    RECIP_W'((RECIP_ONE +  25 - 1) /  25),
    RECIP_W'((RECIP_ONE +  49 - 1) /  49),
    RECIP_W'((RECIP_ONE +  81 - 1) /  81),
    RECIP_W'((RECIP_ONE + 121 - 1) / 121),
    RECIP_W'((RECIP_ONE + 169 - 1) / 169),
    RECIP_W'((RECIP_ONE + 225 - 1) / 225),
    RECIP_W'((RECIP_ONE + 289 - 1) / 289),
    RECIP_W'((RECIP_ONE + 361 - 1) / 361),
    RECIP_W'((RECIP_ONE + 441 - 1) / 441),
    RECIP_W'((RECIP_ONE + 529 - 1) / 529),
    RECIP_W'((RECIP_ONE + 625 - 1) / 625),
    RECIP_W'((RECIP_ONE + 729 - 1) / 729),
    RECIP_W'((RECIP_ONE + 841 - 1) / 841),
    RECIP_W'((RECIP_ONE + 961 - 1) / 961)
  };

  // Per-pixel control flags handed from the sequencer to the accumulator
  typedef struct packed {
    logic emit;      // pixel completes an output window
    logic last;      // that window is the final one of the frame
    logic col_zero;  // first padded column of a row
    logic col_ge_k;  // a column leaves the window
    logic row_zero;  // first padded row: column sums start from zero
    logic row_ge_k;  // a quotient row leaves the column sums
  } nbs_flags_t;

endpackage

// File: rtl/nbs_seq.sv
module nbs_seq #(
  parameter int MAX_WIDTH  = nbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = nbs_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = nbs_pkg::DEF_MAX_KERNEL,
  localparam int PAD_COLS  = MAX_WIDTH + MAX_KERNEL,
  localparam int CW        = $clog2(PAD_COLS),
  localparam int QAW       = $clog2(MAX_KERNEL * PAD_COLS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_en,
  input  logic [nbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nbs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  input  logic [nbs_pkg::PIX_W-1:0]         noise_value,
  input  logic                              take,
  output logic                              in_stall,
  output logic                              issue,
  output logic [nbs_pkg::PIX_W-1:0]         quot,
  output logic [QAW-1:0]                    qaddr,
  output logic [CW-1:0]                     caddr,
  output logic [nbs_pkg::KERN_W-1:0]        k_m1,
  output nbs_pkg::nbs_flags_t               flags
);

  localparam int RW       = $clog2(MAX_HEIGHT + MAX_KERNEL);
  localparam int KMAX_ODD = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
  localparam int PROD_W   = nbs_pkg::RECIP_W + nbs_pkg::PIX_W;

  logic [nbs_pkg::CFG_DATA_W-1:0] image_width;
  logic [nbs_pkg::CFG_DATA_W-1:0] image_height;
  logic [nbs_pkg::KSIZE_W-1:0]    kernel_size;

  logic [CW-1:0]             col;
  logic [RW-1:0]             row;
  logic [nbs_pkg::KERN_W-1:0] slot;
  logic [QAW-1:0]            base;

  logic [CW:0]               w_eff;
  logic [RW:0]               h_eff;
  logic [nbs_pkg::KERN_W-1:0] k_odd;
  logic [nbs_pkg::KERN_W-1:0] k;
  logic [CW:0]               col_inc;
  logic [RW:0]               row_inc;
  logic                      col_wrap;
  logic                      row_wrap;
  logic                      cfg_restart;
  logic [PROD_W-1:0]         prod;

  always_comb begin
    if (image_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(image_width);
    end
    if (image_height == '0) begin
      h_eff = (RW+1)'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(image_height);
    end
    k_odd = nbs_pkg::KERN_W'(kernel_size) | nbs_pkg::KERN_W'(1);
    k = (32'(k_odd) > KMAX_ODD) ? nbs_pkg::KERN_W'(KMAX_ODD) : k_odd;
  end

  assign k_m1    = k - nbs_pkg::KERN_W'(1);
  assign col_inc = (CW+1)'(col) + (CW+1)'(1);
  assign row_inc = (RW+1)'(row) + (RW+1)'(1);
  assign col_wrap = col_inc >= w_eff + (CW+1)'(k);
  assign row_wrap = row_inc >= h_eff + (RW+1)'(k);

  assign in_stall = !take;
  assign issue    = in_valid && take;

  assign cfg_restart = cfg_en && (cfg_index == nbs_pkg::REG_WIDTH ||
                                  cfg_index == nbs_pkg::REG_HEIGHT ||
                                  cfg_index == nbs_pkg::REG_KERNEL);

  // Divide by K*K through a reciprocal multiply
  assign prod = PROD_W'(noise_value) * PROD_W'(nbs_pkg::RECIP[k[nbs_pkg::KERN_W-1:1]]);
  assign quot = prod[nbs_pkg::RECIP_SHIFT +: nbs_pkg::PIX_W];

  assign qaddr = base + QAW'(col);
  assign caddr = col;

  always_comb begin
    flags.emit     = ((RW+1)'(row) >= (RW+1)'(k_m1)) &&
                     ((RW+1)'(row) <  h_eff + (RW+1)'(k_m1)) &&
                     ((CW+1)'(col) >= (CW+1)'(k_m1)) &&
                     ((CW+1)'(col) <  w_eff + (CW+1)'(k_m1));
    flags.last     = (row_inc == h_eff + (RW+1)'(k_m1)) &&
                     (col_inc == w_eff + (CW+1)'(k_m1));
    flags.col_zero = (col == '0);
    flags.col_ge_k = ((CW+1)'(col) >= (CW+1)'(k));
    flags.row_zero = (row == '0);
    flags.row_ge_k = ((RW+1)'(row) >= (RW+1)'(k));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= nbs_pkg::RST_WIDTH;
      image_height <= nbs_pkg::RST_HEIGHT;
      kernel_size  <= nbs_pkg::RST_KERNEL;
    end else if (cfg_en) begin
      unique case (cfg_index)
        nbs_pkg::REG_WIDTH:  image_width  <= cfg_data;
        nbs_pkg::REG_HEIGHT: image_height <= cfg_data;
        nbs_pkg::REG_KERNEL: kernel_size  <= cfg_data[nbs_pkg::KSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
      base <= '0;
    end else if (issue) begin
      if (col_wrap) begin
        col <= '0;
        if (row_wrap) begin
          row  <= '0;
          slot <= '0;
          base <= '0;
        end else begin
          row <= row_inc[RW-1:0];
          if (slot + nbs_pkg::KERN_W'(1) == k) begin
            slot <= '0;
            base <= '0;
          end else begin
            slot <= slot + nbs_pkg::KERN_W'(1);
            base <= base + QAW'(PAD_COLS);
          end
        end
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

endmodule

// File: rtl/nbs_accum.sv
module nbs_accum #(
  parameter int MAX_WIDTH  = nbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = nbs_pkg::DEF_MAX_KERNEL,
  localparam int PAD_COLS  = MAX_WIDTH + MAX_KERNEL,
  localparam int QDEPTH    = MAX_KERNEL * PAD_COLS,
  localparam int CW        = $clog2(PAD_COLS),
  localparam int QAW       = $clog2(QDEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        issue,
  input  logic [nbs_pkg::PIX_W-1:0]   quot,
  input  logic [QAW-1:0]              qaddr,
  input  logic [CW-1:0]               caddr,
  input  logic [nbs_pkg::KERN_W-1:0]  k_m1,
  input  nbs_pkg::nbs_flags_t         flags,
  input  logic                        out_stall,
  output logic                        take,
  output logic                        out_valid,
  output logic [nbs_pkg::PIX_W-1:0]   smooth_value,
  output logic                        last_pixel
);

  logic [nbs_pkg::PIX_W-1:0] qmem [QDEPTH];
  logic [nbs_pkg::PIX_W-1:0] cmem [PAD_COLS];
  logic [nbs_pkg::PIX_W-1:0] qrd;
  logic [nbs_pkg::PIX_W-1:0] crd;

  logic                      s1_valid;
  logic [nbs_pkg::PIX_W-1:0] s1_quot;
  logic [QAW-1:0]            s1_qaddr;
  logic [CW-1:0]             s1_col;
  nbs_pkg::nbs_flags_t       s1_flags;

  logic [nbs_pkg::PIX_W-1:0] hist [nbs_pkg::HIST_DEPTH];
  logic [nbs_pkg::PIX_W-1:0] win_sum;

  logic                      s1_adv;
  logic [nbs_pkg::PIX_W-1:0] q_old;
  logic [nbs_pkg::PIX_W-1:0] cs_prev;
  logic [nbs_pkg::PIX_W-1:0] cs_next;
  logic [nbs_pkg::PIX_W-1:0] ws_base;
  logic [nbs_pkg::PIX_W-1:0] ws_drop;
  logic [nbs_pkg::PIX_W-1:0] win_sum_next;

  assign s1_adv = s1_valid && (!s1_flags.emit || !(out_valid && out_stall));
  assign take   = !s1_valid || s1_adv;

  // Read-modify-write: an entry recurs at least two transactions apart, so it is rewritten before it is read again
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      qmem[s1_qaddr] <= s1_quot;
    end
    if (issue) begin
      qrd <= qmem[qaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      cmem[s1_col] <= cs_next;
    end
    if (issue) begin
      crd <= cmem[caddr];
    end
  end

  always_comb begin
    q_old        = s1_flags.row_ge_k ? qrd : '0;
    cs_prev      = s1_flags.row_zero ? '0 : crd;
    cs_next      = cs_prev + s1_quot - q_old;
    ws_base      = s1_flags.col_zero ? '0 : win_sum;
    ws_drop      = s1_flags.col_ge_k ? hist[k_m1] : '0;
    win_sum_next = ws_base + cs_next - ws_drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_quot  <= quot;
      s1_qaddr <= qaddr;
      s1_col   <= caddr;
      s1_flags <= flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_sum <= '0;
    end else if (s1_adv) begin
      win_sum <= win_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hist[0] <= cs_next;
      for (int i = 1; i < nbs_pkg::HIST_DEPTH; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_flags.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags.emit) begin
      smooth_value <= win_sum_next;
      last_pixel   <= s1_flags.last;
    end
  end

endmodule

// File: rtl/noise_box_smoother.sv
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_en                    cfg_index, cfg_data
// in        in         in_valid / in_stall       noise_value
// out       out        out_valid / out_stall     smooth_value, last_pixel
//
// One padded pixel per cycle sustained while out_stall holds no result; a
// result is registered in stage 1, then in the output register. The rate is set by the
// read-modify-write loop on the registered quotient-row and column-sum reads.
// Reset is synchronous; it clears control state and starts a frame. Memory
// contents need no clearing pass: the first padded row seeds column sums from
// zero. in_stall rises only while a finished result waits on out_stall.
module noise_box_smoother #(
  parameter int MAX_WIDTH  = nbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = nbs_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = nbs_pkg::DEF_MAX_KERNEL
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_en,
  input  logic [nbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [nbs_pkg::PIX_W-1:0]        noise_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [nbs_pkg::PIX_W-1:0]        smooth_value,
  output logic                             last_pixel
);

  localparam int PAD_COLS = MAX_WIDTH + MAX_KERNEL;
  localparam int CW       = $clog2(PAD_COLS);
  localparam int QAW      = $clog2(MAX_KERNEL * PAD_COLS);

  logic                       issue;
  logic                       take;
  logic [nbs_pkg::PIX_W-1:0]  quot;
  logic [QAW-1:0]             qaddr;
  logic [CW-1:0]              caddr;
  logic [nbs_pkg::KERN_W-1:0] k_m1;
  nbs_pkg::nbs_flags_t        flags;

  // Hold the registers, walk the padded raster, divide each pixel by K*K
  nbs_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .noise_value (noise_value),
    .take        (take),
    .in_stall    (in_stall),
    .issue       (issue),
    .quot        (quot),
    .qaddr       (qaddr),
    .caddr       (caddr),
    .k_m1        (k_m1),
    .flags       (flags)
  );

  // Update column sums in memory, slide the row window, register the result
  nbs_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .issue        (issue),
    .quot         (quot),
    .qaddr        (qaddr),
    .caddr        (caddr),
    .k_m1         (k_m1),
    .flags        (flags),
    .out_stall    (out_stall),
    .take         (take),
    .out_valid    (out_valid),
    .smooth_value (smooth_value),
    .last_pixel   (last_pixel)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  // Padded row length of the widest frame; sizes the column memories.
  localparam int PAD_COLS    = nbs_pkg::DEF_MAX_WIDTH + nbs_pkg::DEF_MAX_KERNEL;
  // Index past the last register; the block must drop writes to it.
  localparam logic [nbs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Idle edges after the last predicted result, as a margin for the pipe.
  localparam int TAIL_CYCLES = 12;
  // Long receiver hold-off that backs the pipe up into in_stall.
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 30;
  localparam int RANDOM_ITEMS = 380;
  localparam int MIN_RESULTS  = 48;
  // Pixels sent into each frame with a saturated dimension.
  localparam int SAT_ITEMS    = 24;
  // Corner pixel values for the one-pixel window: quotient equals the pixel.
  localparam logic [nbs_pkg::PIX_W-1:0] CORNER_PIX [8] = '{
    8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [nbs_pkg::PIX_W-1:0] smooth;
    logic                      last;
  } window_t;

  // Tracks the smoother state, predicts one window sum per qualifying pixel
  // and checks the block's results against the oldest prediction.
  class window_scoreboard;
    window_t                            expected_windows[$];
    logic [nbs_pkg::CFG_DATA_W-1:0]     width_reg;
    logic [nbs_pkg::CFG_DATA_W-1:0]     height_reg;
    logic [nbs_pkg::KSIZE_W-1:0]        kernel_reg;
    logic [nbs_pkg::PIX_W-1:0] quot_rows [nbs_pkg::DEF_MAX_KERNEL][PAD_COLS];
    logic [nbs_pkg::PIX_W-1:0] col_sums [PAD_COLS];
    logic [nbs_pkg::PIX_W-1:0] win_sum;
    int unsigned      col_pos;
    int unsigned      row_pos;
    int               failures;
    int               results_seen;

    function new();
      width_reg    = nbs_pkg::RST_WIDTH;
      height_reg   = nbs_pkg::RST_HEIGHT;
      kernel_reg   = nbs_pkg::RST_KERNEL;
      failures     = 0;
      results_seen = 0;
      foreach (quot_rows[r, c]) quot_rows[r][c] = '0;
      restart();
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned vmax);
      if (v == 0) return 1;
      return (v > vmax) ? vmax : v;
    endfunction

    function int unsigned side();
      int unsigned k;
      int unsigned kmax;
      k    = kernel_reg;
      kmax = (nbs_pkg::DEF_MAX_KERNEL % 2 == 1) ? nbs_pkg::DEF_MAX_KERNEL :
                                                  nbs_pkg::DEF_MAX_KERNEL - 1;
      if (k % 2 == 0) k++;
      return (k > kmax) ? kmax : k;
    endfunction

    function int unsigned frame_pixels();
      return (clamp_dim(width_reg, nbs_pkg::DEF_MAX_WIDTH) + side()) *
             (clamp_dim(height_reg, nbs_pkg::DEF_MAX_HEIGHT) + side());
    endfunction

    function void restart();
      foreach (col_sums[c]) col_sums[c] = '0;
      win_sum = '0;
      col_pos = 0;
      row_pos = 0;
    endfunction

    function void write_register(logic [nbs_pkg::CFG_IDX_W-1:0] idx,
                                 logic [nbs_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        nbs_pkg::REG_WIDTH:  width_reg  = data;
        nbs_pkg::REG_HEIGHT: height_reg = data;
        nbs_pkg::REG_KERNEL: kernel_reg = data[nbs_pkg::KSIZE_W-1:0];
        default:    return;  // no register there: no restart either
      endcase
      restart();
    endfunction

    function void take_pixel(logic [nbs_pkg::PIX_W-1:0] pix);
      int unsigned w, h, k, col, row, slot;
      logic [nbs_pkg::PIX_W-1:0] q, old, leaving;
      window_t res;
      w    = clamp_dim(width_reg, nbs_pkg::DEF_MAX_WIDTH);
      h    = clamp_dim(height_reg, nbs_pkg::DEF_MAX_HEIGHT);
      k    = side();
      col  = col_pos;
      row  = row_pos;
      slot = row % k;
      q    = nbs_pkg::PIX_W'(int'(pix) / (k * k));
      // Drop the quotient that falls out of the column, add the new one.
      old  = (row >= k) ? quot_rows[slot][col] : '0;
      col_sums[col]         = col_sums[col] + q - old;
      quot_rows[slot][col]  = q;
      if (col == 0) win_sum = '0;
      leaving = (col >= k) ? col_sums[col - k] : '0;
      win_sum = win_sum + col_sums[col] - leaving;
      if (row + 1 >= k && col + 1 >= k && row + 1 - k < h && col + 1 - k < w) begin
        res.smooth = win_sum;
        res.last   = (row + 1 - k == h - 1) && (col + 1 - k == w - 1);
        expected_windows.push_back(res);
      end
      col++;
      if (col >= w + k) begin
        col = 0;
        row++;
        if (row >= h + k) begin
          restart();
          return;
        end
      end
      col_pos = col;
      row_pos = row;
    endfunction

    function void check_window(logic [nbs_pkg::PIX_W-1:0] smooth, logic last);
      window_t exp_win;
      if (expected_windows.size() == 0) begin
        $error("unexpected result: smooth_value=%0d last_pixel=%0b", smooth, last);
        failures++;
        return;
      end
      exp_win = expected_windows.pop_front();
      results_seen++;
      if (smooth !== exp_win.smooth) begin
        $error("smooth_value: expected %0d, actual %0d", exp_win.smooth, smooth);
        failures++;
      end
      if (last !== exp_win.last) begin
        $error("last_pixel: expected %0b, actual %0b", exp_win.last, last);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_windows.size();
    endfunction
  endclass

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           cfg_en      = 1'b0;
  logic [nbs_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [nbs_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                           in_valid    = 1'b0;
  logic                           in_stall;
  logic [nbs_pkg::PIX_W-1:0]      noise_value = '0;
  logic                           out_valid;
  logic                           out_stall   = 1'b0;
  logic [nbs_pkg::PIX_W-1:0]      smooth_value;
  logic                           last_pixel;

  window_scoreboard board;

  // Idle controls: the sender's is only read by the main process.
  bit          tx_gaps_on   = 1'b1;
  bit          rx_gaps_on   = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;

  noise_box_smoother uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_en       (cfg_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .noise_value  (noise_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .smooth_value (smooth_value),
    .last_pixel   (last_pixel)
  );

  always #5 clk = ~clk;

  // Observe every transaction at the edge that completes it. Register
  // writes, pixels and results are never accepted in a way where the
  // order among them at one edge could change a prediction.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.take_pixel(noise_value);
    if (!rst && out_valid && !out_stall) board.check_window(smooth_value, last_pixel);
    if (!rst && cfg_en) board.write_register(cfg_index, cfg_data);
  end

  // Receiver: serve a pending hold-off request first, counting it down here;
  // otherwise stall at random or not at all.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else if (rx_gaps_on) begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly uniform pixels, with the range ends mixed in.
  function automatic logic [nbs_pkg::PIX_W-1:0] pick_noise();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return nbs_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Offer one pixel and hold it until the block takes it. Return at the
  // accepting edge with in_valid still high so back-to-back pixels flow.
  task automatic send_pixel(input logic [nbs_pkg::PIX_W-1:0] value);
    if (tx_gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    noise_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(pick_noise());
  endtask

  // Stop offering, wait for every predicted result, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Leave cfg_en high so back-to-back writes need no second assignment per edge.
  task automatic cfg_write(input logic [nbs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nbs_pkg::CFG_DATA_W-1:0] data);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic cfg_done();
    cfg_en    <= 1'b0;
    cfg_index <= nbs_pkg::CFG_IDX_W'($urandom_range(3));
    cfg_data  <= nbs_pkg::CFG_DATA_W'($urandom_range(2047));
  endtask

  task automatic configure(input logic [nbs_pkg::CFG_DATA_W-1:0] w,
                           input logic [nbs_pkg::CFG_DATA_W-1:0] h,
                           input logic [nbs_pkg::CFG_DATA_W-1:0] kdata);
    cfg_write(nbs_pkg::REG_WIDTH, w);
    cfg_write(nbs_pkg::REG_HEIGHT, h);
    cfg_write(nbs_pkg::REG_KERNEL, kdata);
    cfg_done();
  endtask

  // Kernel register data with random bits above the 4-bit field.
  function automatic logic [nbs_pkg::CFG_DATA_W-1:0] kernel_word(input int unsigned nibble);
    return {7'($urandom_range(127)), 4'(nibble)};
  endfunction

  initial begin
    int unsigned random_items;
    int unsigned count;
    int unsigned pause_at;
    int unsigned nibble;
    int          phase;
    logic [nbs_pkg::CFG_DATA_W-1:0] w;
    logic [nbs_pkg::CFG_DATA_W-1:0] h;

    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset geometry, then abandon the frame with a register write.
    send_pixel(8'h00);
    send_pixel(8'hFF);
    drain();

    // Zero kernel acts as a one-pixel window; two frames cover the wrap.
    configure(11'd1, 11'd1, 11'd0);
    foreach (CORNER_PIX[i]) send_pixel(CORNER_PIX[i]);
    drain();

    // Pause mid-frame, write the unused index, resume: no restart allowed.
    configure(11'd2, 11'd1, 11'd1);
    send_random(3);
    drain();
    cfg_write(REG_UNUSED, nbs_pkg::CFG_DATA_W'($urandom_range(2047)));
    cfg_done();
    send_random(3);
    drain();

    // Zero dimensions count as one.
    configure(11'd0, 11'd0, kernel_word(1));
    send_random(4);
    drain();

    // Random phases: each picks a geometry and mostly sends whole frames;
    // the rest stop at a random point, which breaks the frame off.
    random_items = 0;
    phase        = 0;
    while (phase < 5 || random_items < RANDOM_ITEMS || board.results_seen < MIN_RESULTS) begin
      // Run a stretch with no idling on either side.
      tx_gaps_on = !(phase >= 3 && phase <= 4);
      rx_gaps_on <= !(phase >= 3 && phase <= 4);
      w      = nbs_pkg::CFG_DATA_W'($urandom_range(1, 5));
      h      = nbs_pkg::CFG_DATA_W'($urandom_range(1, 3));
      nibble = $urandom_range(0, 4);
      case (phase)
        1: begin                    // even side raised to the largest window
          w      = 11'd1;
          h      = 11'd1;
          nibble = 14;
        end
        2: begin                    // dense results for the receiver hold-off
          w      = 11'd6;
          h      = 11'd4;
          nibble = 1;
        end
        default: ;
      endcase
      configure(w, h, kernel_word(nibble));
      if (phase >= 1 && phase <= 2) begin
        count = board.frame_pixels();
      end else if ($urandom_range(99) < 70) begin
        count = board.frame_pixels() * $urandom_range(1, 2);
      end else begin
        count = $urandom_range(1, board.frame_pixels());
      end
      // Hold the sender back until every result is out, now and then.
      pause_at = (phase == 0 || $urandom_range(3) == 0) ? $urandom_range(1, count) : 0;
      if (phase == 2) hold_requests <= hold_requests + 1;
      for (int unsigned i = 1; i <= count; i++) begin
        send_pixel(pick_noise());
        if (i == pause_at) drain();
      end
      random_items += count;
      drain();
      phase++;
    end

    // Width at or above the maximum saturates: the opening pixels of the clamped row.
    configure(nbs_pkg::CFG_DATA_W'($urandom_range(1024, 2047)),
              nbs_pkg::CFG_DATA_W'($urandom_range(1, 3)),
              kernel_word($urandom_range(0, 1)));
    send_random(SAT_ITEMS);
    drain();

    // Height at or above the maximum saturates: the opening rows of a narrow frame.
    configure(11'd1, nbs_pkg::CFG_DATA_W'($urandom_range(1024, 2047)),
              kernel_word($urandom_range(0, 1)));
    send_random(SAT_ITEMS);
    drain();

    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
